// ===== rtl/hcdf_pkg.sv =====
// Shared types and constants for the binned histogram with cumulative report.
`default_nettype none

package hcdf_pkg;

    localparam int DATA_W       = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int BIN_INDEX_W  = 6;
    localparam int MAX_BINS_DEF = 64;
    localparam int COUNT_W_DEF  = 32;

    localparam logic [CFG_IDX_W-1:0] REG_LOW_BOUND  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_BOUND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH  = 2'd2;

    localparam logic [DATA_W-1:0] LOW_BOUND_RST  = 16'd0;
    localparam logic [DATA_W-1:0] HIGH_BOUND_RST = 16'hFFFF;
    localparam logic [DATA_W-1:0] BIN_WIDTH_RST  = 16'd1024;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NB_DIV,
        ST_SMP_DIV,
        ST_SMP_WR,
        ST_REP_RD,
        ST_REP_ACC
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic nb_start;
        logic nb_load;
        logic smp_start;
        logic smp_rd;
        logic smp_wr;
        logic rep_init;
        logic rep_rd;
        logic rep_next;
        logic out_load;
        logic clear_all;
    } ctrl_cmd_t;

    typedef struct packed {
        logic nb_stale;
        logic nb_zero;
        logic smp_ok;
        logic div_done;
        logic last_bin;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/hcdf_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module hcdf_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [hcdf_pkg::DATA_W-1:0]  dividend,
    input  wire logic [hcdf_pkg::DATA_W-1:0]  divisor,
    output logic      [hcdf_pkg::DATA_W-1:0]  quotient,
    output logic                              done
);

    localparam int DW = hcdf_pkg::DATA_W;
    localparam int SW = $clog2(DW);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [SW-1:0] step_reg, step_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [DW-1:0] dvs_reg, dvs_next;

    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          fits;

    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
            // a zero width counts as one
            dvs_next  = (divisor == '0) ? DW'(1) : divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[DW-1:0] : shifted[DW-1:0];
            quo_next  = {quo_reg[DW-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == SW'(DW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

// ===== rtl/hcdf_datapath.sv =====
// Datapath: bound registers, bin count memory, divider, accumulator, output register.
`default_nettype none

module hcdf_datapath #(
    parameter int MAX_BINS    = hcdf_pkg::MAX_BINS_DEF,
    parameter int COUNT_WIDTH = hcdf_pkg::COUNT_W_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [hcdf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [hcdf_pkg::DATA_W-1:0]        cfg_wdata,
    input  wire logic [hcdf_pkg::DATA_W-1:0]        sample_value,
    input  wire hcdf_pkg::ctrl_cmd_t                cmd,
    output hcdf_pkg::dp_status_t                    sts,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [hcdf_pkg::BIN_INDEX_W-1:0]        bin_index,
    output logic [COUNT_WIDTH-1:0]                  cumulative_count,
    output logic                                    last
);

    localparam int DW    = hcdf_pkg::DATA_W;
    localparam int BIW   = hcdf_pkg::BIN_INDEX_W;
    localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int NB_W  = $clog2(MAX_BINS + 1);

    // configuration
    logic [DW-1:0]   low_reg, low_next;
    logic [DW-1:0]   high_reg, high_next;
    logic [DW-1:0]   width_reg, width_next;
    logic            stale_reg, stale_next;
    logic [NB_W-1:0] nb_reg, nb_next;

    // divider
    logic            div_start;
    logic [DW-1:0]   div_dividend;
    logic [DW-1:0]   div_q;
    logic            div_done;

    // bin memory
    logic [COUNT_WIDTH-1:0] bin_mem [MAX_BINS];
    logic [MAX_BINS-1:0]    vld_reg, vld_next;
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   rd_vld_reg;
    logic                   mem_rd;
    logic [IDX_W-1:0]       rd_addr;
    logic [IDX_W-1:0]       smp_idx;
    logic [IDX_W-1:0]       idx_reg;
    logic [COUNT_WIDTH-1:0] rd_cnt;
    logic [COUNT_WIDTH-1:0] inc_cnt;

    // report
    logic [IDX_W-1:0]       i_reg, i_next;
    logic [COUNT_WIDTH-1:0] acc_reg, acc_next;
    logic [COUNT_WIDTH:0]   acc_sum;
    logic [COUNT_WIDTH-1:0] acc_sat;
    logic                   last_bin;
    logic                   out_free;

    logic                   out_valid_reg, out_valid_next;
    logic [BIW-1:0]         out_idx_reg;
    logic [COUNT_WIDTH-1:0] out_cnt_reg;
    logic                   out_last_reg;

    // ---------------------------------------------------------------- config
    always_comb
    begin
        low_next   = low_reg;
        high_next  = high_reg;
        width_next = width_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                hcdf_pkg::REG_LOW_BOUND:  low_next   = cfg_wdata;
                hcdf_pkg::REG_HIGH_BOUND: high_next  = cfg_wdata;
                hcdf_pkg::REG_BIN_WIDTH:  width_next = cfg_wdata;
                default:                  ;
            endcase
        end
    end

    // a write during a recompute marks the bin count stale again
    always_comb
    begin
        stale_next = stale_reg;
        if (cmd.nb_start)
            stale_next = 1'b0;
        if (cfg_we)
            stale_next = 1'b1;
    end

    always_comb
    begin
        nb_next = nb_reg;
        if (cmd.nb_load)
        begin
            if (high_reg < low_reg)
                nb_next = '0;
            else if (div_q > DW'(MAX_BINS))
                nb_next = NB_W'(MAX_BINS);
            else
                nb_next = NB_W'(div_q);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg   <= hcdf_pkg::LOW_BOUND_RST;
            high_reg  <= hcdf_pkg::HIGH_BOUND_RST;
            width_reg <= hcdf_pkg::BIN_WIDTH_RST;
            stale_reg <= 1'b1;
            nb_reg    <= '0;
        end
        else
        begin
            low_reg   <= low_next;
            high_reg  <= high_next;
            width_reg <= width_next;
            stale_reg <= stale_next;
            nb_reg    <= nb_next;
        end
    end

    // --------------------------------------------------------------- divider
    assign div_start    = cmd.nb_start | cmd.smp_start;
    assign div_dividend = cmd.nb_start ? (high_reg - low_reg) : (sample_value - low_reg);

    hcdf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (width_reg),
        .quotient (div_q),
        .done     (div_done)
    );

    // fold indexes past the last bin into the last bin
    assign smp_idx = (div_q >= DW'(nb_reg)) ? IDX_W'(nb_reg - NB_W'(1)) : IDX_W'(div_q);

    // ------------------------------------------------------------ bin memory
    assign mem_rd  = cmd.smp_rd | cmd.rep_rd;
    assign rd_addr = cmd.rep_rd ? i_reg : smp_idx;
    assign rd_cnt  = rd_vld_reg ? rd_data_reg : '0;
    assign inc_cnt = (rd_cnt == '1) ? rd_cnt : rd_cnt + 1'b1;

    always_ff @(posedge clk)
    begin
        if (mem_rd)
        begin
            rd_data_reg <= bin_mem[rd_addr];
            rd_vld_reg  <= vld_reg[rd_addr];
        end
        if (cmd.smp_rd)
            idx_reg <= smp_idx;
        if (cmd.smp_wr)
            bin_mem[idx_reg] <= inc_cnt;
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (cmd.clear_all)
            vld_next = '0;
        else if (cmd.smp_wr)
            vld_next[idx_reg] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // ---------------------------------------------------------------- report
    assign acc_sum  = {1'b0, acc_reg} + {1'b0, rd_cnt};
    assign acc_sat  = acc_sum[COUNT_WIDTH] ? '1 : acc_sum[COUNT_WIDTH-1:0];
    assign last_bin = ((NB_W'(i_reg) + NB_W'(1)) == nb_reg);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        i_next   = i_reg;
        acc_next = acc_reg;
        if (cmd.rep_init)
        begin
            i_next   = '0;
            acc_next = '0;
        end
        else
        begin
            if (cmd.rep_next)
                i_next = i_reg + 1'b1;
            if (cmd.out_load)
                acc_next = acc_sat;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        i_reg   <= i_next;
        acc_reg <= acc_next;
        if (cmd.out_load)
        begin
            out_idx_reg  <= BIW'(i_reg);
            out_cnt_reg  <= acc_sat;
            out_last_reg <= last_bin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign out_valid        = out_valid_reg;
    assign bin_index        = out_idx_reg;
    assign cumulative_count = out_cnt_reg;
    assign last             = out_last_reg;

    // ---------------------------------------------------------------- status
    assign sts.nb_stale = stale_reg;
    assign sts.nb_zero  = (nb_reg == '0);
    assign sts.smp_ok   = (nb_reg != '0) && (sample_value >= low_reg)
                          && (sample_value <= high_reg);
    assign sts.div_done = div_done;
    assign sts.last_bin = last_bin;
    assign sts.out_free = out_free;

`ifndef NO_ASSERTIONS
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("result loaded over a waiting result");

    a_nb_cap: assert property (@(posedge clk) disable iff (!rst_n)
        nb_reg <= NB_W'(MAX_BINS))
        else $error("bin count above cap");

    a_wr_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.smp_wr |-> (nb_reg != '0) && (NB_W'(idx_reg) < nb_reg))
        else $error("sample written to a bin not in use");
`endif

endmodule

`default_nettype wire

// ===== rtl/hcdf_ctrl.sv =====
// Controller state machine for the binned histogram.
`default_nettype none

module hcdf_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  kind,
    input  wire hcdf_pkg::dp_status_t  sts,
    output hcdf_pkg::ctrl_cmd_t        cmd
);

    hcdf_pkg::state_t state_reg, state_next;
    logic             ready;
    logic             accept;

    assign ready  = (state_reg == hcdf_pkg::ST_IDLE) && !sts.nb_stale;
    assign accept = in_valid && ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hcdf_pkg::ST_IDLE:
            begin
                if (sts.nb_stale)
                    state_next = hcdf_pkg::ST_NB_DIV;
                else if (accept)
                begin
                    if (kind == hcdf_pkg::KIND_TICK)
                    begin
                        if (!sts.nb_zero)
                            state_next = hcdf_pkg::ST_REP_RD;
                    end
                    else if (sts.smp_ok)
                        state_next = hcdf_pkg::ST_SMP_DIV;
                end
            end
            hcdf_pkg::ST_NB_DIV:
            begin
                if (sts.div_done)
                    state_next = hcdf_pkg::ST_IDLE;
            end
            hcdf_pkg::ST_SMP_DIV:
            begin
                if (sts.div_done)
                    state_next = hcdf_pkg::ST_SMP_WR;
            end
            hcdf_pkg::ST_SMP_WR:
                state_next = hcdf_pkg::ST_IDLE;
            hcdf_pkg::ST_REP_RD:
                state_next = hcdf_pkg::ST_REP_ACC;
            hcdf_pkg::ST_REP_ACC:
            begin
                if (sts.out_free)
                    state_next = sts.last_bin ? hcdf_pkg::ST_IDLE : hcdf_pkg::ST_REP_RD;
            end
            default:
                state_next = hcdf_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.in_ready = ready;
        unique case (state_reg)
            hcdf_pkg::ST_IDLE:
            begin
                if (sts.nb_stale)
                    cmd.nb_start = 1'b1;
                else if (accept)
                begin
                    if (kind == hcdf_pkg::KIND_TICK)
                    begin
                        // no bins in use: nothing to report, still clear
                        if (sts.nb_zero)
                            cmd.clear_all = 1'b1;
                        else
                            cmd.rep_init = 1'b1;
                    end
                    else if (sts.smp_ok)
                        cmd.smp_start = 1'b1;
                end
            end
            hcdf_pkg::ST_NB_DIV:
                cmd.nb_load = sts.div_done;
            hcdf_pkg::ST_SMP_DIV:
                cmd.smp_rd = sts.div_done;
            hcdf_pkg::ST_SMP_WR:
                cmd.smp_wr = 1'b1;
            hcdf_pkg::ST_REP_RD:
                cmd.rep_rd = 1'b1;
            hcdf_pkg::ST_REP_ACC:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.clear_all = sts.last_bin;
                    cmd.rep_next  = !sts.last_bin;
                end
            end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= hcdf_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef NO_ASSERTIONS
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> (state_reg == hcdf_pkg::ST_NB_DIV)
                         || (state_reg == hcdf_pkg::ST_SMP_DIV))
        else $error("divider finished outside a divide state");

    a_rep_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hcdf_pkg::ST_REP_ACC) && !sts.out_free
        |=> (state_reg == hcdf_pkg::ST_REP_ACC))
        else $error("report advanced while output was blocked");

    a_fresh_nb: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.smp_start || cmd.rep_init) |-> !sts.nb_stale)
        else $error("request started on a stale bin count");
`endif

endmodule

`default_nettype wire

// ===== rtl/binned_histogram_cdf.sv =====
// Top level of the binned histogram with cumulative report.
`default_nettype none

// A sample request (kind 0) inside [low_bound, high_bound] adds one to bin
// (sample_value - low_bound) / bin_width; samples outside the bounds or with no
// bins in use are dropped. A tick request (kind 1) sends one result per bin in
// use, bin 0 first, carrying the saturating running sum, with last set on the
// final bin, then clears all bins. The bin index comes from a bit-serial divider
// that resolves one quotient bit per cycle, so a counted sample occupies the
// block through its accept, 16 divide steps, a memory read and a memory write;
// a dropped sample is only accepted. A tick, after its accept, does one counter
// memory read and then one accumulate per bin in use, and waits whenever the
// output stalls. After any register write the bin count is recomputed with the
// same divider, which holds off the next request until the recompute after the
// last write is done, longer when that write lands while a recompute is already
// running. A result waits in an output register, so the next request can be
// taken while it is pending.
module binned_histogram_cdf #(
    parameter int MAX_BINS    = hcdf_pkg::MAX_BINS_DEF,
    parameter int COUNT_WIDTH = hcdf_pkg::COUNT_W_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [hcdf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [hcdf_pkg::DATA_W-1:0]       cfg_wdata,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              kind,
    input  wire logic [hcdf_pkg::DATA_W-1:0]       sample_value,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [hcdf_pkg::BIN_INDEX_W-1:0]       bin_index,
    output logic [COUNT_WIDTH-1:0]                 cumulative_count,
    output logic                                   last
);

    hcdf_pkg::ctrl_cmd_t  cmd;
    hcdf_pkg::dp_status_t sts;

    hcdf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .sts      (sts),
        .cmd      (cmd)
    );

    hcdf_datapath #(
        .MAX_BINS    (MAX_BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .sample_value     (sample_value),
        .cmd              (cmd),
        .sts              (sts),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .bin_index        (bin_index),
        .cumulative_count (cumulative_count),
        .last             (last)
    );

    assign in_stall = !cmd.in_ready;

endmodule

`default_nettype wire

// ===== tb/binned_histogram_cdf_test.sv =====
// Testbench for binned_histogram_cdf: directed table, then randomized samples and ticks.
module binned_histogram_cdf_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_W          = hcdf_pkg::DATA_W;
    localparam int CFG_IDX_W       = hcdf_pkg::CFG_IDX_W;
    localparam int BIN_INDEX_W     = hcdf_pkg::BIN_INDEX_W;
    localparam int NBINS_MAX       = hcdf_pkg::MAX_BINS_DEF;
    localparam int CNT_W           = hcdf_pkg::COUNT_W_DEF;
    localparam int SETTLE_CYCLES   = 40;
    localparam int RX_HOLD_CYCLES  = 400;
    localparam int N_PHASES        = 10;
    localparam int ITEMS_PER_PHASE = 23;
    localparam int N_DIR           = 31;

    typedef struct packed {
        logic [BIN_INDEX_W-1:0] bin;
        logic [CNT_W-1:0]       cum;
        logic                   fin;
    } cdf_point_t;

    typedef enum logic [1:0] {ROW_CFG, ROW_SAMPLE, ROW_TICK} row_op_t;

    // Config rows: a = low, b = high, c = width. Sample rows: a = value.
    // Checked tick rows carry the result count and the final cumulative count.
    typedef struct packed {
        row_op_t           op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] c;
        logic              chk;
        logic [6:0]        n_bins;
        logic [31:0]       total;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [DATA_W-1:0]      cfg_wdata;
    logic                   in_valid;
    logic                   in_stall;
    logic                   kind;
    logic [DATA_W-1:0]      sample_value;
    logic                   out_valid;
    logic                   out_stall;
    logic [BIN_INDEX_W-1:0] bin_index;
    logic [CNT_W-1:0]       cumulative_count;
    logic                   last;

    // Shadow of the block: register copies and bin counters
    logic [DATA_W-1:0] lo_m = hcdf_pkg::LOW_BOUND_RST;
    logic [DATA_W-1:0] hi_m = hcdf_pkg::HIGH_BOUND_RST;
    logic [DATA_W-1:0] bw_m = hcdf_pkg::BIN_WIDTH_RST;
    logic [CNT_W-1:0]  bin_tally [NBINS_MAX] = '{default: '0};
    cdf_point_t        cdf_expected_q [$];

    int  errors          = 0;
    int  items_sent      = 0;
    int  ticks_sent      = 0;
    int  results_checked = 0;
    int  cfg_writes      = 0;
    logic [CNT_W-1:0] last_cum = '0;
    bit  idle_on     = 1'b1;
    bit  rx_hold_req = 1'b0;

    stim_row_t dir_rows [N_DIR] = '{
        '{ROW_TICK,   16'd0,     16'd0,     16'd0,     1'b1, 7'd63, 32'd0},
        '{ROW_SAMPLE, 16'd0,     16'd0,     16'd0,     1'b0, 7'd0,  32'd0},
        '{ROW_SAMPLE, 16'd65535, 16'd0,     16'd0,     1'b0, 7'd0,  32'd0},
        '{ROW_SAMPLE, 16'd1023,  16'd0,     16'd0,     1'b0, 7'd0,  32'd0},
        '{ROW_SAMPLE, 16'd64511, 16'd0,     16'd0,     1'b0, 7'd0,  32'd0},
        '{ROW_TICK,   16'd0,     16'd0,     16'd0,     1'b1, 7'd63, 32'd4},
        // zero width acts as one; bin count capped at the maximum
        '{ROW_CFG,    16'd100,   16'd200,   16'd0,     1'b0, 7'd0,  32'd0},
        '{ROW_SAMPLE, 16'd99,    16'd0,     16'd0,     1'b0, 7'd0,  32'd0},
        '{ROW_SAMPLE, 16'd100,   16'd0,     16'd0,     1'b0, 7'd0,  32'd0},
        '{ROW_SAMPLE, 16'd200,   16'd0,     16'd0,     1'b0, 7'd0,  32'd0},
        '{ROW_SAMPLE, 16'd201,   16'd0,     16'd0,     1'b0, 7'd0,  32'd0},
        '{ROW_SAMPLE, 16'd163,   16'd0,     16'd0,     1'b0, 7'd0,  32'd0},
        '{ROW_TICK,   16'd0,     16'd0,     16'd0,     1'b1, 7'd64, 32'd3},
        // high below low: no bins
        '{ROW_CFG,    16'd65535, 16'd0,     16'd1,     1'b0, 7'd0,  32'd0},
        '{ROW_SAMPLE, 16'd65535, 16'd0,     16'd0,     1'b0, 7'd0,  32'd0},
        '{ROW_TICK,   16'd0,     16'd0,     16'd0,     1'b1, 7'd0,  32'd0},
        '{ROW_CFG,    16'd0,     16'd65535, 16'd65535, 1'b0, 7'd0,  32'd0},
        '{ROW_SAMPLE, 16'd65535, 16'd0,     16'd0,     1'b0, 7'd0,  32'd0},
        '{ROW_SAMPLE, 16'd43690, 16'd0,     16'd0,     1'b0, 7'd0,  32'd0},
        '{ROW_SAMPLE, 16'd21845, 16'd0,     16'd0,     1'b0, 7'd0,  32'd0},
        '{ROW_TICK,   16'd0,     16'd0,     16'd0,     1'b1, 7'd1,  32'd3},
        // span narrower than one bin: no bins
        '{ROW_CFG,    16'd10,    16'd20,    16'd11,    1'b0, 7'd0,  32'd0},
        '{ROW_SAMPLE, 16'd15,    16'd0,     16'd0,     1'b0, 7'd0,  32'd0},
        '{ROW_TICK,   16'd0,     16'd0,     16'd0,     1'b1, 7'd0,  32'd0},
        // shrink the bin count with counts held in a high bin
        '{ROW_CFG,    16'd0,     16'd640,   16'd10,    1'b0, 7'd0,  32'd0},
        '{ROW_SAMPLE, 16'd5,     16'd0,     16'd0,     1'b0, 7'd0,  32'd0},
        '{ROW_SAMPLE, 16'd639,   16'd0,     16'd0,     1'b0, 7'd0,  32'd0},
        '{ROW_CFG,    16'd0,     16'd100,   16'd10,    1'b0, 7'd0,  32'd0},
        '{ROW_TICK,   16'd0,     16'd0,     16'd0,     1'b1, 7'd10, 32'd1},
        '{ROW_CFG,    16'd0,     16'd640,   16'd10,    1'b0, 7'd0,  32'd0},
        '{ROW_TICK,   16'd0,     16'd0,     16'd0,     1'b1, 7'd64, 32'd0}
    };

    binned_histogram_cdf u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .kind             (kind),
        .sample_value     (sample_value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .bin_index        (bin_index),
        .cumulative_count (cumulative_count),
        .last             (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic void flag_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("mismatch: %s", msg);
    endfunction

    function automatic int eff_width();
        return (bw_m == '0) ? 1 : int'(bw_m);
    endfunction

    function automatic int bins_active();
        int nb;
        if (hi_m < lo_m)
            return 0;
        nb = (int'(hi_m) - int'(lo_m)) / eff_width();
        return (nb > NBINS_MAX) ? NBINS_MAX : nb;
    endfunction

    // Count a sample into its bin, or turn a tick into the cumulative report.
    function automatic void hist_predict(input logic k, input logic [DATA_W-1:0] v);
        int nb;
        int idx;
        logic [CNT_W:0] acc;
        cdf_point_t pt;
        nb = bins_active();
        if (k == hcdf_pkg::KIND_SAMPLE)
        begin
            if (nb != 0 && v >= lo_m && v <= hi_m)
            begin
                idx = (int'(v) - int'(lo_m)) / eff_width();
                if (idx >= nb)
                    idx = nb - 1;
                if (bin_tally[idx] != '1)
                    bin_tally[idx] = bin_tally[idx] + 1'b1;
            end
        end
        else
        begin
            acc = '0;
            for (int i = 0; i < nb; i++)
            begin
                acc = acc + {1'b0, bin_tally[i]};
                if (acc[CNT_W])
                    acc = {1'b0, {CNT_W{1'b1}}};
                pt.bin = BIN_INDEX_W'(i);
                pt.cum = acc[CNT_W-1:0];
                pt.fin = (i == nb - 1);
                cdf_expected_q.push_back(pt);
            end
            for (int i = 0; i < NBINS_MAX; i++)
                bin_tally[i] = '0;
        end
    endfunction

    always @(posedge clk)
    begin : scoreboard
        cdf_point_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    hcdf_pkg::REG_LOW_BOUND:  lo_m = cfg_wdata;
                    hcdf_pkg::REG_HIGH_BOUND: hi_m = cfg_wdata;
                    hcdf_pkg::REG_BIN_WIDTH:  bw_m = cfg_wdata;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                hist_predict(kind, sample_value);
            if (out_valid && !out_stall)
            begin
                if (cdf_expected_q.size() == 0)
                begin
                    flag_error($sformatf("unexpected result bin %0d count %0d last %0b",
                                         bin_index, cumulative_count, last));
                end
                else
                begin
                    want = cdf_expected_q.pop_front();
                    if (bin_index !== want.bin || cumulative_count !== want.cum
                        || last !== want.fin)
                        flag_error($sformatf(
                            "bin exp %0d got %0d, count exp %0d got %0d, last exp %0b got %0b",
                            want.bin, bin_index, want.cum, cumulative_count, want.fin, last));
                end
                results_checked++;
                last_cum = cumulative_count;
            end
        end
    end

    // Result side: random stall bursts, or one long hold when asked for.
    initial
    begin : rx_side
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                out_stall <= 1'b1;
                repeat (RX_HOLD_CYCLES) @(negedge clk);
                rx_hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, 18);
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_request(input logic k, input logic [DATA_W-1:0] v);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        sample_value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
        if (k == hcdf_pkg::KIND_TICK)
            ticks_sent++;
    endtask

    // Drop valid, wait for every expected result, then keep idling for the requested extra settle.
    task automatic settle_idle(input int extra);
        in_valid <= 1'b0;
        @(negedge clk);
        while (cdf_expected_q.size() != 0)
            @(negedge clk);
        repeat (extra + 1) @(negedge clk);
    endtask

    task automatic set_cfg(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi,
                           input logic [DATA_W-1:0] w);
        cfg_we    <= 1'b1;
        cfg_index <= hcdf_pkg::REG_LOW_BOUND;
        cfg_wdata <= lo;
        @(negedge clk);
        cfg_index <= hcdf_pkg::REG_HIGH_BOUND;
        cfg_wdata <= hi;
        @(negedge clk);
        cfg_index <= hcdf_pkg::REG_BIN_WIDTH;
        cfg_wdata <= w;
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_writes += 3;
    endtask

    // Mostly values spread over the bins in use and just above them, plus bound edges and raw noise.
    function automatic logic [DATA_W-1:0] pick_sample();
        int nb;
        int w;
        int x;
        nb = bins_active();
        w  = eff_width();
        unique case ($urandom_range(0, 5))
            0: return DATA_W'($urandom);
            1:
            begin
                unique case ($urandom_range(0, 3))
                    0: return lo_m - 1'b1;
                    1: return lo_m;
                    2: return hi_m;
                    default: return hi_m + 1'b1;
                endcase
            end
            default:
            begin
                if (nb == 0)
                    return DATA_W'($urandom);
                x = int'(lo_m) + $urandom_range(0, nb) * w + $urandom_range(0, w - 1);
                return (x > 65535) ? hi_m : DATA_W'(x);
            end
        endcase
    endfunction

    initial
    begin : stimulus
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] w;
        stim_row_t row;
        int base;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = hcdf_pkg::REG_LOW_BOUND;
        cfg_wdata    = '0;
        in_valid     = 1'b0;
        kind         = hcdf_pkg::KIND_SAMPLE;
        sample_value = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < N_DIR; r++)
        begin
            row = dir_rows[r];
            unique case (row.op)
                ROW_CFG:
                begin
                    settle_idle(SETTLE_CYCLES);
                    set_cfg(row.a, row.b, row.c);
                end
                ROW_SAMPLE: send_request(hcdf_pkg::KIND_SAMPLE, row.a);
                default:
                begin
                    settle_idle(0);
                    base = results_checked;
                    send_request(hcdf_pkg::KIND_TICK, row.a);
                    settle_idle(0);
                    if (row.chk)
                    begin
                        if (results_checked - base != int'(row.n_bins))
                            flag_error($sformatf("row %0d: %0d results, want %0d",
                                                 r, results_checked - base, row.n_bins));
                        else if (row.n_bins != 0 && last_cum != row.total)
                            flag_error($sformatf("row %0d: total %0d, want %0d",
                                                 r, last_cum, row.total));
                    end
                end
            endcase
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            unique case (p)
                0:
                begin
                    lo = 16'd0;     hi = 16'hFFFF; w = 16'd1;
                end
                1:
                begin
                    lo = 16'd0;     hi = 16'hFFFF; w = 16'hFFFF;
                end
                2:
                begin
                    lo = 16'hFFFF;  hi = 16'hFFFF; w = 16'd1;
                end
                3:
                begin
                    lo = 16'd0;     hi = 16'hFFFF; w = 16'd0;
                end
                5:
                begin
                    lo = 16'd0;     hi = 16'd6399; w = 16'd100;
                end
                default:
                begin
                    lo = DATA_W'($urandom_range(0, 65000));
                    hi = lo + DATA_W'($urandom_range(0, 65535 - int'(lo)));
                    w  = DATA_W'((int'(hi) - int'(lo)) / $urandom_range(1, 80));
                    if ($urandom_range(0, 7) == 0)
                    begin
                        w  = lo;
                        lo = hi;
                        hi = w;
                        w  = DATA_W'($urandom_range(1, 200));
                    end
                end
            endcase
            settle_idle(SETTLE_CYCLES);
            set_cfg(lo, hi, w);
            idle_on = (p != 4) && (p != N_PHASES - 1);

            // Long output hold while requests keep coming: the report backs up
            // and the input stalls.
            if (p == 5)
            begin
                @(posedge clk);
                rx_hold_req = 1'b1;
                @(negedge clk);
                send_request(hcdf_pkg::KIND_TICK, DATA_W'($urandom));
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 6) == 0)
                    send_request(hcdf_pkg::KIND_TICK, DATA_W'($urandom));
                else
                    send_request(hcdf_pkg::KIND_SAMPLE, pick_sample());
            end
            send_request(hcdf_pkg::KIND_TICK, DATA_W'($urandom));
        end

        settle_idle(SETTLE_CYCLES);
        $display("ran %0d requests (%0d ticks) over %0d register writes",
                 items_sent, ticks_sent, cfg_writes);
        $display("checked %0d cumulative results, %0d errors", results_checked, errors);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
